// ----- sv/aer_pkg.sv -----
`timescale 1ns / 1ps
package aer_pkg;

    typedef logic [7:0] t_byte;
    typedef t_byte t_block [16];

    typedef enum logic [1:0] {
        OP_FULL  = 2'd0,
        OP_FINAL = 2'd1,
        OP_KEY   = 2'd2,
        OP_SPARE = 2'd3
    } t_op;

    typedef struct packed {
        logic [63:0] state_hi;
        logic [63:0] state_lo;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [1:0]  operation;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } t_out_beat;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8).
    function automatic t_byte xtime(input t_byte a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ----- sv/aer_stream_if.sv -----
`timescale 1ns / 1ps
interface aer_stream_if #(
    parameter int Width = 8
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/aer_round_logic.sv -----
`timescale 1ns / 1ps
// Combinational SubBytes, ShiftRows, MixColumns, AddRoundKey; op picks a subset.
module aer_round_logic (
    input  aer_pkg::t_in_beat  i_beat,
    output aer_pkg::t_out_beat o_beat
);
    aer_pkg::t_block s_in;
    aer_pkg::t_block s_sub;
    aer_pkg::t_block s_mix;
    aer_pkg::t_block s_sel;
    logic [63:0]     w_hi;
    logic [63:0]     w_lo;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            s_in[i]     = i_beat.state_hi[56-8*i +: 8];
            s_in[8 + i] = i_beat.state_lo[56-8*i +: 8];
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                s_sub[r + 4*c] = aer_pkg::SBOX[s_in[r + 4*((c + r) % 4)]];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            s_mix[4*c]   = aer_pkg::xtime(s_sub[4*c]) ^ aer_pkg::xtime(s_sub[4*c+1])
                         ^ s_sub[4*c+1] ^ s_sub[4*c+2] ^ s_sub[4*c+3];
            s_mix[4*c+1] = s_sub[4*c] ^ aer_pkg::xtime(s_sub[4*c+1])
                         ^ aer_pkg::xtime(s_sub[4*c+2]) ^ s_sub[4*c+2] ^ s_sub[4*c+3];
            s_mix[4*c+2] = s_sub[4*c] ^ s_sub[4*c+1] ^ aer_pkg::xtime(s_sub[4*c+2])
                         ^ aer_pkg::xtime(s_sub[4*c+3]) ^ s_sub[4*c+3];
            s_mix[4*c+3] = aer_pkg::xtime(s_sub[4*c]) ^ s_sub[4*c] ^ s_sub[4*c+1]
                         ^ s_sub[4*c+2] ^ aer_pkg::xtime(s_sub[4*c+3]);
        end
    end

    always_comb begin
        unique case (aer_pkg::t_op'(i_beat.operation))
            aer_pkg::OP_FULL:  s_sel = s_mix;
            aer_pkg::OP_FINAL: s_sel = s_sub;
            default:           s_sel = s_in;  // add key only, and the unused code
        endcase
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_hi[56-8*i +: 8] = s_sel[i];
            w_lo[56-8*i +: 8] = s_sel[8 + i];
        end
    end

    assign o_beat.result_hi = w_hi ^ i_beat.key_hi;
    assign o_beat.result_lo = w_lo ^ i_beat.key_lo;
endmodule

// ----- sv/aes_encrypt_round_top.sv -----
`timescale 1ns / 1ps
// Channel  | Direction | Payload
// in_ch    | sink      | state_hi, state_lo, key_hi, key_lo, operation
// out_ch   | source    | result_hi, result_lo
//
// One beat is taken every cycle unless the output stalls. A beat is captured
// in an input register, the round runs as one combinational pass, and the
// result is loaded into the output register, which offers it on out_ch.
// Reset clears only the two valid flags. A stall on the output backs up
// through both stages; each stage refills in the cycle it empties.
module aes_encrypt_round_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aer_stream_if.sink      in_ch,
    aer_stream_if.source    out_ch
);
    aer_pkg::t_in_beat  r_in;
    aer_pkg::t_out_beat r_out;
    aer_pkg::t_out_beat w_res;
    logic               r_in_vld;
    logic               r_out_vld;
    logic               w_out_ld;
    logic               w_in_ld;

    // Output register loads whenever it is empty or being drained.
    assign w_out_ld = !r_out_vld || out_ch.ready;
    // Input register frees when its content moves on.
    assign w_in_ld  = !r_in_vld || w_out_ld;

    assign in_ch.ready  = w_in_ld;
    assign out_ch.valid = r_out_vld;
    assign out_ch.data  = r_out;

    aer_round_logic u_round (
        .i_beat (r_in),
        .o_beat (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_ld) begin
                r_in_vld <= in_ch.valid;
            end
            if (w_out_ld) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ld && in_ch.valid) begin
            r_in <= in_ch.data;
        end
        if (w_out_ld && r_in_vld) begin
            r_out <= w_res;
        end
    end

`ifndef SYNTHESIS
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed while stalled");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken with both stages full");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && w_out_ld |=> r_out_vld)
        else $error("beat lost between stages");
`endif
endmodule
